// ----- rtl/tbp_pkg.sv -----
// Shared constants and counter helper for the tournament branch predictor.
package tbp_pkg;

  localparam int LocalIndexBits    = 10;
  localparam int LocalCounterBits  = 3;
  localparam int GlobalCounterBits = 2;
  localparam int PathHistoryBits   = 12;

  localparam int AddrWidth    = 32;
  localparam int CtrMaxWidth  = 4;

  localparam logic OpPredict = 1'b0;
  localparam logic OpUpdate  = 1'b1;

  // Saturating step of a counter of up to four bits; max_i is its top value.
  function automatic logic [CtrMaxWidth-1:0] sat_move(
    input logic [CtrMaxWidth-1:0] v_i,
    input logic                   up_i,
    input logic [CtrMaxWidth-1:0] max_i
  );
    logic [CtrMaxWidth-1:0] r;
    if (up_i) begin
      r = (v_i < max_i) ? v_i + 4'd1 : max_i;
    end else begin
      r = (v_i != '0) ? v_i - 4'd1 : '0;
    end
    return r;
  endfunction

endpackage

// ----- rtl/tbp_if.sv -----
// Request and response channel interfaces of the branch predictor.
interface tbp_req_if;
  logic                            valid;
  logic                            ready;
  logic                            op;
  logic [tbp_pkg::AddrWidth-1:0]   branch_address;
  logic                            conditional;
  logic                            outcome_taken;

  modport source (output valid, op, branch_address, conditional, outcome_taken,
                  input ready);
  modport sink   (input valid, op, branch_address, conditional, outcome_taken,
                  output ready);
endinterface

interface tbp_rsp_if;
  logic valid;
  logic ready;
  logic predict_taken;

  modport source (output valid, predict_taken, input ready);
  modport sink   (input valid, predict_taken, output ready);
endinterface

// ----- rtl/tbp_ram.sv -----
// Single-port-write, single-port-read synchronous RAM with registered read data.
module tbp_ram #(
  parameter int Width    = 2,
  parameter int AddrBits = 12
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [AddrBits-1:0] waddr_i,
  input  logic [Width-1:0]    wdata_i,
  input  logic                re_i,
  input  logic [AddrBits-1:0] raddr_i,
  output logic [Width-1:0]    rdata_o
);

  logic [Width-1:0] mem [2**AddrBits];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/tournament_branch_predictor_unit.sv -----
// Tournament branch predictor: local, global and choice tables in synchronous RAMs.
// Each item passes through the history read, the local counter read and the
// evaluate-and-write-back step in order; a predict result goes to the output register.
// A new item is accepted only once the last is through; a predict waits in evaluate while
// the output holds. After reset a clearing pass writes zero to every address of all tables
// before the first item is accepted.
module tournament_branch_predictor_unit #(
  parameter int LOCAL_INDEX_BITS    = tbp_pkg::LocalIndexBits,
  parameter int LOCAL_COUNTER_BITS  = tbp_pkg::LocalCounterBits,
  parameter int GLOBAL_COUNTER_BITS = tbp_pkg::GlobalCounterBits,
  parameter int PATH_HISTORY_BITS   = tbp_pkg::PathHistoryBits
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tbp_req_if.sink    req_i,
  tbp_rsp_if.source  rsp_o
);

  localparam int LIB = LOCAL_INDEX_BITS;
  localparam int LCB = LOCAL_COUNTER_BITS;
  localparam int GCB = GLOBAL_COUNTER_BITS;
  localparam int PHB = PATH_HISTORY_BITS;
  localparam int ClrBits = (LIB > PHB) ? LIB : PHB;
  localparam int CMW = tbp_pkg::CtrMaxWidth;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_EVAL
  } state_e;

  state_e           state_q, state_d;
  logic [ClrBits-1:0] clr_q, clr_d;
  logic [PHB-1:0]   path_q, path_d;
  logic             op_q, cond_q, taken_q;
  logic [LIB-1:0]   hidx_q;
  logic [LIB-1:0]   lidx_q;
  logic             out_valid_q, out_valid_d;
  logic             out_taken_q, out_taken_d;

  logic             accept;
  logic             clearing;

  // RAM ports
  logic             lht_we, lct_we, gct_we, cct_we;
  logic [LIB-1:0]   lht_waddr, lct_waddr;
  logic [PHB-1:0]   gct_waddr;
  logic [LIB-1:0]   lht_wdata, lht_rdata;
  logic [LCB-1:0]   lct_wdata, lct_rdata;
  logic [GCB-1:0]   gct_wdata, gct_rdata, cct_wdata, cct_rdata;

  // Evaluation
  logic             lpred, gpred, use_global, pred;
  logic             upd;
  logic [LCB-1:0]   lct_next;
  logic [GCB-1:0]   gct_next, cct_next;

  assign accept   = req_i.valid && req_i.ready;
  assign clearing = (state_q == ST_CLEAR);

  assign req_i.ready         = (state_q == ST_IDLE);
  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.predict_taken = out_taken_q;

  assign lpred      = lct_rdata[LCB-1];
  assign gpred      = gct_rdata[GCB-1];
  assign use_global = cct_rdata[GCB-1];
  assign pred       = !cond_q ? 1'b1 : (use_global ? gpred : lpred);

  assign lct_next = LCB'(tbp_pkg::sat_move(CMW'(lct_rdata), taken_q, CMW'({LCB{1'b1}})));
  assign gct_next = GCB'(tbp_pkg::sat_move(CMW'(gct_rdata), taken_q, CMW'({GCB{1'b1}})));
  assign cct_next = GCB'(tbp_pkg::sat_move(CMW'(cct_rdata), lpred != taken_q,
                                           CMW'({GCB{1'b1}})));

  assign upd = (state_q == ST_EVAL) && (op_q == tbp_pkg::OpUpdate) && cond_q;

  always_comb begin
    if (clearing) begin
      lht_we    = 1'b1;
      lct_we    = 1'b1;
      gct_we    = 1'b1;
      cct_we    = 1'b1;
      lht_waddr = clr_q[LIB-1:0];
      lct_waddr = clr_q[LIB-1:0];
      gct_waddr = clr_q[PHB-1:0];
      lht_wdata = '0;
      lct_wdata = '0;
      gct_wdata = '0;
      cct_wdata = '0;
    end else begin
      lht_we    = upd;
      lct_we    = upd;
      gct_we    = upd;
      cct_we    = upd && (lpred != gpred);
      lht_waddr = hidx_q;
      lct_waddr = lidx_q;
      gct_waddr = path_q;
      lht_wdata = {lidx_q[LIB-2:0], taken_q};
      lct_wdata = lct_next;
      gct_wdata = gct_next;
      cct_wdata = cct_next;
    end
  end

  tbp_ram #(.Width(LIB), .AddrBits(LIB)) u_lht (
    .clk_i   (clk_i),
    .we_i    (lht_we),
    .waddr_i (lht_waddr),
    .wdata_i (lht_wdata),
    .re_i    (accept),
    .raddr_i (req_i.branch_address[LIB+1:2]),
    .rdata_o (lht_rdata)
  );

  tbp_ram #(.Width(LCB), .AddrBits(LIB)) u_lct (
    .clk_i   (clk_i),
    .we_i    (lct_we),
    .waddr_i (lct_waddr),
    .wdata_i (lct_wdata),
    .re_i    (state_q == ST_READ),
    .raddr_i (lht_rdata),
    .rdata_o (lct_rdata)
  );

  tbp_ram #(.Width(GCB), .AddrBits(PHB)) u_gct (
    .clk_i   (clk_i),
    .we_i    (gct_we),
    .waddr_i (gct_waddr),
    .wdata_i (gct_wdata),
    .re_i    (accept),
    .raddr_i (path_q),
    .rdata_o (gct_rdata)
  );

  tbp_ram #(.Width(GCB), .AddrBits(PHB)) u_cct (
    .clk_i   (clk_i),
    .we_i    (cct_we),
    .waddr_i (gct_waddr),
    .wdata_i (cct_wdata),
    .re_i    (accept),
    .raddr_i (path_q),
    .rdata_o (cct_rdata)
  );

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    path_d      = path_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    out_taken_d = out_taken_q;
    case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (&clr_q) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        state_d = ST_EVAL;
      end
      ST_EVAL: begin
        if (op_q == tbp_pkg::OpPredict) begin
          // hold until the output register is free
          if (!out_valid_q || rsp_o.ready) begin
            out_valid_d = 1'b1;
            out_taken_d = pred;
            state_d     = ST_IDLE;
          end
        end else begin
          path_d  = {path_q[PHB-2:0], taken_q};
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      path_q      <= '0;
      out_valid_q <= 1'b0;
      out_taken_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      path_q      <= path_d;
      out_valid_q <= out_valid_d;
      out_taken_q <= out_taken_d;
    end
  end

  // Item fields and the fetched local history, held for the item in flight
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= req_i.op;
      cond_q  <= req_i.conditional;
      taken_q <= req_i.outcome_taken;
      hidx_q  <= req_i.branch_address[LIB+1:2];
    end
    if (state_q == ST_READ) begin
      lidx_q <= lht_rdata;
    end
  end

endmodule

// ----- dv/testbench.sv -----
// Self-checking bench for the tournament branch predictor: directed items, then random loops.
`timescale 1ns / 1ps

module testbench;

  localparam int LocalDepth  = 1 << tbp_pkg::LocalIndexBits;
  localparam int PathDepth   = 1 << tbp_pkg::PathHistoryBits;
  localparam int LocalMax    = (1 << tbp_pkg::LocalCounterBits) - 1;
  localparam int GlobalMax   = (1 << tbp_pkg::GlobalCounterBits) - 1;
  localparam int ItemTarget  = 900;
  localparam int CycleLimit  = 150000;
  localparam int HoldCycles  = 300;
  localparam int IdlePercent = 29;

  typedef struct {
    logic [tbp_pkg::AddrWidth-1:0] addr;
    logic                          taken;
  } direction_t;

  // Mirror of the predictor tables plus the queue of predicted directions.
  class direction_scoreboard;
    logic [tbp_pkg::LocalIndexBits-1:0]    hist_mirror [LocalDepth];
    logic [tbp_pkg::LocalCounterBits-1:0]  local_ctr   [LocalDepth];
    logic [tbp_pkg::GlobalCounterBits-1:0] global_ctr  [PathDepth];
    logic [tbp_pkg::GlobalCounterBits-1:0] choice_ctr  [PathDepth];
    logic [tbp_pkg::PathHistoryBits-1:0]   path;
    direction_t                            pending [$];
    int unsigned                           errors;

    function new();
      foreach (hist_mirror[i]) begin
        hist_mirror[i] = '0;
        local_ctr[i]   = '0;
      end
      foreach (global_ctr[i]) begin
        global_ctr[i] = '0;
        choice_ctr[i] = '0;
      end
      path   = '0;
      errors = 0;
    endfunction

    function int unsigned bump(int unsigned v, bit up, int unsigned top);
      if (up) begin
        return (v < top) ? v + 1 : top;
      end
      return (v > 0) ? v - 1 : 0;
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= 10) begin
        $display("%s", msg);
      end
    endfunction

    // Predict items queue a direction; update items train the tables.
    function void note_request(logic op, logic [tbp_pkg::AddrWidth-1:0] addr, logic cond,
                               logic taken);
      logic [tbp_pkg::LocalIndexBits-1:0]  hidx;
      logic [tbp_pkg::LocalIndexBits-1:0]  lidx;
      logic [tbp_pkg::PathHistoryBits-1:0] gidx;
      logic                                lpred;
      logic                                gpred;
      logic                                use_global;
      direction_t                          d;
      hidx       = addr[tbp_pkg::LocalIndexBits+1:2];
      lidx       = hist_mirror[hidx];
      gidx       = path;
      lpred      = local_ctr[lidx][tbp_pkg::LocalCounterBits-1];
      gpred      = global_ctr[gidx][tbp_pkg::GlobalCounterBits-1];
      use_global = choice_ctr[gidx][tbp_pkg::GlobalCounterBits-1];
      if (op == tbp_pkg::OpPredict) begin
        d.addr  = addr;
        d.taken = cond ? (use_global ? gpred : lpred) : 1'b1;
        pending.push_back(d);
        return;
      end
      if (cond) begin
        // move the chooser only when the two sides disagree
        if (lpred != gpred) begin
          choice_ctr[gidx] = tbp_pkg::GlobalCounterBits'(bump(choice_ctr[gidx],
                                                              lpred != taken, GlobalMax));
        end
        local_ctr[lidx]   = tbp_pkg::LocalCounterBits'(bump(local_ctr[lidx], taken,
                                                             LocalMax));
        global_ctr[gidx]  = tbp_pkg::GlobalCounterBits'(bump(global_ctr[gidx], taken,
                                                              GlobalMax));
        hist_mirror[hidx] = {lidx[tbp_pkg::LocalIndexBits-2:0], taken};
      end
      path = {path[tbp_pkg::PathHistoryBits-2:0], taken};
    endfunction

    function void check_direction(logic got);
      direction_t d;
      if (pending.size() == 0) begin
        flag($sformatf("unexpected predict_taken=%b with nothing pending", got));
        return;
      end
      d = pending.pop_front();
      if (got !== d.taken) begin
        flag($sformatf("predict_taken mismatch addr=%h expected=%b actual=%b",
                       d.addr, d.taken, got));
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  bit                  quiet;
  bit                  hold_rsp;
  int unsigned         items_sent;
  int unsigned         cycles;
  direction_scoreboard sb;

  tbp_req_if req_if ();
  tbp_rsp_if rsp_if ();

  tournament_branch_predictor_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (req_if.valid && req_if.ready) begin
        sb.note_request(req_if.op, req_if.branch_address, req_if.conditional,
                        req_if.outcome_taken);
      end
      if (rsp_if.valid && rsp_if.ready) begin
        sb.check_direction(rsp_if.predict_taken);
      end
    end
  end

  // Response side: random stalls, one long hold-off, a stall-free window.
  initial begin
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_rsp) begin
        rsp_if.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_rsp = 1'b0;
      end else begin
        rsp_if.ready <= quiet || ($urandom_range(99) >= IdlePercent);
      end
    end
  end

  task automatic send_item(input logic op, input logic [tbp_pkg::AddrWidth-1:0] addr,
                           input logic cond, input logic taken);
    while (!quiet && $urandom_range(99) < IdlePercent) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid          <= 1'b1;
    req_if.op             <= op;
    req_if.branch_address <= addr;
    req_if.conditional    <= cond;
    req_if.outcome_taken  <= taken;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    items_sent++;
    if (items_sent == 200) begin
      hold_rsp = 1'b1;
    end
    quiet = (items_sent >= 500) && (items_sent < 650);
  endtask

  // Fetch-time lookup followed by the resolved update of the same branch.
  task automatic run_branch(input logic [tbp_pkg::AddrWidth-1:0] addr, input logic cond,
                            input logic taken, input bit with_lookup);
    if (with_lookup) begin
      send_item(tbp_pkg::OpPredict, addr, cond, 1'($urandom_range(1)));
    end
    send_item(tbp_pkg::OpUpdate, addr, cond, taken);
  endtask

  initial begin
    logic [tbp_pkg::AddrWidth-1:0] pool [8];
    logic [tbp_pkg::AddrWidth-1:0] br [4];
    logic [3:0]                    pattern [4];
    int unsigned                   period [4];
    bit                            follows [4];
    int unsigned                   n_br;
    int unsigned                   iters;
    logic                          outcome;
    logic                          last;

    sb = new();
    req_if.valid          <= 1'b0;
    req_if.op             <= tbp_pkg::OpPredict;
    req_if.branch_address <= '0;
    req_if.conditional    <= 1'b0;
    req_if.outcome_taken  <= 1'b0;
    rst_ni                <= 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Cleared tables, address extremes, unconditional updates of either outcome.
    send_item(tbp_pkg::OpPredict, 32'h0000_0000, 1'b1, 1'b0);
    send_item(tbp_pkg::OpPredict, 32'hFFFF_FFFF, 1'b0, 1'b1);
    send_item(tbp_pkg::OpPredict, 32'hFFFF_FFFF, 1'b1, 1'b1);
    send_item(tbp_pkg::OpUpdate, 32'hFFFF_FFFF, 1'b0, 1'b0);
    send_item(tbp_pkg::OpUpdate, 32'hAAAA_AAAA, 1'b0, 1'b1);
    send_item(tbp_pkg::OpUpdate, 32'h5555_5555, 1'b1, 1'b0);
    send_item(tbp_pkg::OpUpdate, 32'h0000_0000, 1'b1, 1'b1);
    send_item(tbp_pkg::OpPredict, 32'h0000_0000, 1'b1, 1'b0);
    // Train one branch taken repeatedly, then turn it around.
    repeat (6) run_branch(32'h0000_1004, 1'b1, 1'b1, 1'b1);
    repeat (2) run_branch(32'h0000_1004, 1'b1, 1'b0, 1'b1);

    foreach (pool[i]) pool[i] = $urandom;
    // alias two branches onto one local history entry
    pool[7][tbp_pkg::LocalIndexBits+1:2] = pool[0][tbp_pkg::LocalIndexBits+1:2];

    while (items_sent < ItemTarget) begin
      if ($urandom_range(99) < 15) begin
        repeat ($urandom_range(1, 6)) begin
          send_item(1'($urandom_range(1)), $urandom, 1'($urandom_range(1)),
                    1'($urandom_range(1)));
        end
      end else begin
        n_br  = $urandom_range(1, 4);
        iters = $urandom_range(4, 20);
        for (int i = 0; i < n_br; i++) begin
          br[i]      = pool[$urandom_range(7)];
          period[i]  = $urandom_range(1, 4);
          pattern[i] = 4'($urandom);
          follows[i] = ($urandom_range(3) == 0);
        end
        last = 1'b0;
        for (int it = 0; it < iters && items_sent < ItemTarget; it++) begin
          for (int i = 0; i < n_br; i++) begin
            // correlated branches repeat the previous outcome
            outcome = follows[i] ? last : pattern[i][it % period[i]];
            if ($urandom_range(9) == 0) begin
              outcome = ~outcome;
            end
            if ($urandom_range(19) == 0) begin
              run_branch($urandom, 1'b0, 1'($urandom_range(1)), 1'b1);
            end
            run_branch(br[i], 1'b1, outcome, $urandom_range(9) != 0);
            last = outcome;
          end
        end
      end
    end

    req_if.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/tbp_pkg.sv
rtl/tbp_if.sv
rtl/tbp_ram.sv
rtl/tournament_branch_predictor_unit.sv
dv/testbench.sv
